// ===== rtl/cdc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdc_pkg
// Types, request codes and calendar helper functions for the date counter.
// ----------------------------------------------------------------------------
package cdc_pkg;

	localparam int YEAR_BITS = 16;

	typedef enum logic [2:0] {
		REQ_LOAD      = 3'd0,
		REQ_SET_DAY   = 3'd1,
		REQ_SET_MONTH = 3'd2,
		REQ_SET_YEAR  = 3'd3,
		REQ_NEXT_DAY  = 3'd4,
		REQ_PREV_DAY  = 3'd5,
		REQ_COMPARE   = 3'd6
	} req_code_t;

	typedef struct packed {
		req_code_t             req_type;
		logic [4:0]            in_day;
		logic [3:0]            in_month;
		logic [YEAR_BITS-1:0]  in_year;
	} cdc_req_t;

	typedef struct packed {
		logic [4:0]            cur_day;
		logic [3:0]            cur_month;
		logic [YEAR_BITS-1:0]  cur_year;
		logic                  accepted;
		logic                  stored_less;
		logic                  stored_equal;
		logic                  stored_greater;
		logic                  gregorian_leap;
	} cdc_rsp_t;

	typedef struct packed {
		logic [4:0]            day;
		logic [3:0]            month;
		logic [YEAR_BITS-1:0]  year;
	} cdc_date_t;

	typedef struct packed {
		logic accepted;
		logic less;
		logic equal;
		logic greater;
	} cdc_flags_t;

	localparam cdc_date_t DATE_RESET = '{day: 5'd1, month: 4'd1, year: YEAR_BITS'(1)};

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// inverse of an odd value modulo 2**YEAR_BITS (Newton iteration)
	function automatic logic [YEAR_BITS-1:0] inv_odd(input logic [YEAR_BITS-1:0] a);
		logic [YEAR_BITS-1:0] x;
		x = a;
		for (int i = 0; i < 5; i++) begin
			x = x * (YEAR_BITS'(2) - a * x);
		end
		return x;
	endfunction

	localparam logic [YEAR_BITS-1:0] INV25 = inv_odd(YEAR_BITS'(25));
	localparam logic [YEAR_BITS-1:0] DIV25_LIMIT =
		YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

	// 0 for a month outside 1..12; February leap when year mod 4 is 0
	function automatic logic [4:0] days_in(input logic [3:0] m,
			input logic [YEAR_BITS-1:0] y);
		logic [4:0] n;
		n = 5'd0;
		if (m >= 4'd1 && m <= 4'd12) begin
			n = MONTH_LEN[m - 4'd1];
			if (m == 4'd2 && y[1:0] == 2'b00) begin
				n = n + 5'd1;
			end
		end
		return n;
	endfunction

	// 4/100/400 rule; divisibility by 25 via multiply by inverse
	function automatic logic greg_leap(input logic [YEAR_BITS-1:0] y);
		logic [YEAR_BITS-1:0] prod;
		logic                 div25;
		prod  = y * INV25;
		div25 = (prod <= DIV25_LIMIT);
		return (div25 && y[3:0] == 4'd0) || (!div25 && y[1:0] == 2'b00);
	endfunction

endpackage

// ===== rtl/calendar_date_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_date_counter
// Day/month/year register with load, set, step and compare requests.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one request per transfer:
//   load, set day/month/year, next day, previous day or compare.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one response per
//   request, in order: stored date after the request, accepted flag,
//   compare flags and the 4/100/400 leap flag of the stored year.
//   The request lands in the input register at its accepting edge; the
//   date update, response register and rsp_valid load as it moves on,
//   which a held response with rsp_ready low can delay. Throughput is
//   one request per cycle while rsp_ready is high; the stored date feeds
//   back into the next request with no bubble.
//   When rsp_ready is low, the held response stays put and one more request
//   can sit in the input register; req_ready drops once both are full.
//   Reset (arst_n low) sets the date to 1/1/1 and empties both stages.
// ----------------------------------------------------------------------------
module calendar_date_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cdc_pkg::cdc_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cdc_pkg::cdc_rsp_t rsp
);
	import cdc_pkg::*;

	cdc_req_t   req_s1;
	logic       valid_s1;
	cdc_date_t  date_q;
	cdc_date_t  date_nxt;
	cdc_flags_t flags_nxt;
	cdc_date_t  res_date_s2;
	cdc_flags_t res_flags_s2;
	logic       valid_s2;
	logic       advance;

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	cdc_step u_step (
		.req   (req_s1),
		.cur   (date_q),
		.nxt   (date_nxt),
		.flags (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			date_q   <= DATE_RESET;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				date_q   <= date_nxt;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			res_date_s2  <= date_nxt;
			res_flags_s2 <= flags_nxt;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp = '{
		cur_day:        res_date_s2.day,
		cur_month:      res_date_s2.month,
		cur_year:       res_date_s2.year,
		accepted:       res_flags_s2.accepted,
		stored_less:    res_flags_s2.less,
		stored_equal:   res_flags_s2.equal,
		stored_greater: res_flags_s2.greater,
		gregorian_leap: greg_leap(res_date_s2.year)
	};

	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.stored_less, rsp.stored_equal, rsp.stored_greater}))
		else $error("compare flags not exclusive");

	a_acc_vs_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accepted |-> !(rsp.stored_less || rsp.stored_equal ||
			rsp.stored_greater))
		else $error("accepted set together with compare flag");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		date_q.month >= 4'd1 && date_q.month <= 4'd12 && date_q.day != 5'd0)
		else $error("stored date out of range");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("accepted request lost from input stage");

endmodule

// ===== rtl/cdc_step.sv =====
// ----------------------------------------------------------------------------
// cdc_step
// Next-state and flag logic for one request against the stored date.
// ----------------------------------------------------------------------------
module cdc_step (
	input  cdc_pkg::cdc_req_t   req,
	input  cdc_pkg::cdc_date_t  cur,
	output cdc_pkg::cdc_date_t  nxt,
	output cdc_pkg::cdc_flags_t flags
);
	import cdc_pkg::*;

	logic [4:0]           day_lim;
	logic [4:0]           load_lim;
	logic [3:0]           prev_month;
	logic [YEAR_BITS-1:0] prev_year;
	logic [YEAR_BITS+8:0] key_cur;
	logic [YEAR_BITS+8:0] key_req;

	assign day_lim  = days_in(cur.month, cur.year);
	assign load_lim = days_in(req.in_month, req.in_year);
	assign key_cur  = {cur.year, cur.month, cur.day};
	assign key_req  = {req.in_year, req.in_month, req.in_day};

	always_comb begin
		if (cur.month <= 4'd1) begin
			prev_month = 4'd12;
			prev_year  = cur.year - YEAR_BITS'(1);
		end else begin
			prev_month = cur.month - 4'd1;
			prev_year  = cur.year;
		end
	end

	always_comb begin
		nxt   = cur;
		flags = '0;
		unique case (req.req_type)
			REQ_LOAD: begin
				if (req.in_year != '0 && req.in_day != 5'd0 && req.in_day <= load_lim) begin
					nxt.day        = req.in_day;
					nxt.month      = req.in_month;
					nxt.year       = req.in_year;
					flags.accepted = 1'b1;
				end else begin
					nxt = DATE_RESET;
				end
			end
			REQ_SET_DAY: begin
				if (req.in_day != 5'd0 && req.in_day <= day_lim) begin
					nxt.day        = req.in_day;
					flags.accepted = 1'b1;
				end
			end
			REQ_SET_MONTH: begin
				if (req.in_month >= 4'd1 && req.in_month <= 4'd12) begin
					nxt.month      = req.in_month;
					flags.accepted = 1'b1;
				end
			end
			REQ_SET_YEAR: begin
				if (req.in_year != '0) begin
					nxt.year       = req.in_year;
					flags.accepted = 1'b1;
				end
			end
			REQ_NEXT_DAY: begin
				if ({1'b0, cur.day} + 6'd1 > {1'b0, day_lim}) begin
					nxt.day = 5'd1;
					if (cur.month >= 4'd12) begin
						nxt.month = 4'd1;
						nxt.year  = cur.year + YEAR_BITS'(1);
					end else begin
						nxt.month = cur.month + 4'd1;
					end
				end else begin
					nxt.day = cur.day + 5'd1;
				end
			end
			REQ_PREV_DAY: begin
				if (cur.day <= 5'd1) begin
					nxt.month = prev_month;
					nxt.year  = prev_year;
					nxt.day   = days_in(prev_month, prev_year);
				end else begin
					nxt.day = cur.day - 5'd1;
				end
			end
			REQ_COMPARE: begin
				flags.less    = (key_cur < key_req);
				flags.equal   = (key_cur == key_req);
				flags.greater = (key_cur > key_req);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for calendar_date_counter. A directed table (reset
// date, year wrap both ways, leap days, rejected loads and sets, compares,
// the unused code) runs first, then about a thousand random requests,
// mostly well-formed dates. All response fields are checked against an
// in-bench calendar model or a pinned row, under random stalls on both
// sides and long receiver hold-offs that back up the request channel.
// ----------------------------------------------------------------------------
module testbench;
	import cdc_pkg::*;

	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 1025;
	localparam int CHOKE_CYCLES = 48;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		cdc_req_t r;
		bit       pinned;
		cdc_rsp_t want;
	} dir_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	cdc_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	cdc_rsp_t rsp;

	// calendar model state
	logic [4:0]  cal_day = 5'd1;
	logic [3:0]  cal_month = 4'd1;
	logic [15:0] cal_year = 16'd1;

	cdc_rsp_t date_expect_q[$];
	dir_row_t directed_rows[$];

	bit       row_pinned = 1'b0;
	cdc_rsp_t row_want = '0;
	bit       req_steady = 1'b0;
	bit       rsp_steady = 1'b0;
	bit       choke_rsp = 1'b0;
	int       holdoffs = 0;
	int       err_count = 0;
	int       reqs_accepted = 0;
	int       rsp_checked = 0;
	int       idle_cycles = 0;
	int       seen_code [8] = '{default: 0};

	calendar_date_counter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int month_days(logic [3:0] m, logic [15:0] y);
		int n;
		n = 0;
		if (m >= 4'd1 && m <= 4'd12) begin
			n = MONTH_DAYS[m - 1];
			if (m == 4'd2 && (y % 4) == 0) begin
				n = n + 1;
			end
		end
		return n;
	endfunction

	function automatic bit is_greg_leap(logic [15:0] y);
		return (y % 400) == 0 || ((y % 4) == 0 && (y % 100) != 0);
	endfunction

	function automatic cdc_rsp_t rsp_of(int d, int m, int y, bit acc, bit lt, bit eq,
			bit gt, bit lp);
		cdc_rsp_t o;
		o.cur_day        = 5'(d);
		o.cur_month      = 4'(m);
		o.cur_year       = 16'(y);
		o.accepted       = acc;
		o.stored_less    = lt;
		o.stored_equal   = eq;
		o.stored_greater = gt;
		o.gregorian_leap = lp;
		return o;
	endfunction

	// applies one request to the calendar model, returns the response it gives
	function automatic cdc_rsp_t advance_calendar(cdc_req_t r);
		logic acc, lt, eq, gt;
		acc = 1'b0;
		lt  = 1'b0;
		eq  = 1'b0;
		gt  = 1'b0;
		case (r.req_type)
			REQ_LOAD: begin
				if (r.in_year != 16'd0 && r.in_day >= 1
						&& r.in_day <= month_days(r.in_month, r.in_year)) begin
					cal_day   = r.in_day;
					cal_month = r.in_month;
					cal_year  = r.in_year;
					acc       = 1'b1;
				end else begin
					cal_day   = 5'd1;
					cal_month = 4'd1;
					cal_year  = 16'd1;
				end
			end
			REQ_SET_DAY: begin
				if (r.in_day >= 1 && r.in_day <= month_days(cal_month, cal_year)) begin
					cal_day = r.in_day;
					acc     = 1'b1;
				end
			end
			REQ_SET_MONTH: begin
				if (r.in_month >= 4'd1 && r.in_month <= 4'd12) begin
					cal_month = r.in_month;
					acc       = 1'b1;
				end
			end
			REQ_SET_YEAR: begin
				if (r.in_year != 16'd0) begin
					cal_year = r.in_year;
					acc      = 1'b1;
				end
			end
			REQ_NEXT_DAY: begin
				if (int'(cal_day) + 1 > month_days(cal_month, cal_year)) begin
					cal_day   = 5'd1;
					cal_month = cal_month + 4'd1;
					if (cal_month > 4'd12) begin
						cal_month = 4'd1;
						cal_year  = cal_year + 16'd1;
					end
				end else begin
					cal_day = cal_day + 5'd1;
				end
			end
			REQ_PREV_DAY: begin
				if (cal_day <= 5'd1) begin
					if (cal_month <= 4'd1) begin
						cal_month = 4'd12;
						cal_year  = cal_year - 16'd1;
					end else begin
						cal_month = cal_month - 4'd1;
					end
					cal_day = 5'(month_days(cal_month, cal_year));
				end else begin
					cal_day = cal_day - 5'd1;
				end
			end
			REQ_COMPARE: begin
				if (cal_year != r.in_year) begin
					lt = cal_year < r.in_year;
					gt = cal_year > r.in_year;
				end else if (cal_month != r.in_month) begin
					lt = cal_month < r.in_month;
					gt = cal_month > r.in_month;
				end else if (cal_day != r.in_day) begin
					lt = cal_day < r.in_day;
					gt = cal_day > r.in_day;
				end else begin
					eq = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return rsp_of(cal_day, cal_month, cal_year, acc, lt, eq, gt, is_greg_leap(cal_year));
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [15:0] random_year();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 3));
			1: return 16'($urandom_range(65532, 65535));
			2: return 16'(100 * $urandom_range(1, 655));
			3: return 16'(400 * $urandom_range(1, 163));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cdc_req_t random_request();
		cdc_req_t r;
		int pick;
		int sel;
		pick       = $urandom_range(0, 99);
		r.req_type = REQ_NEXT_DAY;
		r.in_day   = 5'($urandom);
		r.in_month = 4'($urandom);
		r.in_year  = 16'($urandom);
		if (pick < 11) begin
			r.req_type = REQ_LOAD;
			r.in_year  = random_year();
			r.in_month = 4'($urandom_range(1, 12));
			r.in_day   = 5'($urandom_range(1, month_days(r.in_month, r.in_year)));
			if ($urandom_range(0, 2) == 0) begin
				r.in_day = 5'(month_days(r.in_month, r.in_year));
			end
		end else if (pick < 14) begin
			r.req_type = REQ_LOAD;
		end else if (pick < 24) begin
			r.req_type = REQ_SET_DAY;
			if ($urandom_range(0, 3) != 0) begin
				r.in_day = 5'($urandom_range(1, month_days(cal_month, cal_year)));
			end
		end else if (pick < 31) begin
			r.req_type = REQ_SET_MONTH;
			if ($urandom_range(0, 4) != 0) begin
				r.in_month = 4'($urandom_range(1, 12));
			end
		end else if (pick < 36) begin
			r.req_type = REQ_SET_YEAR;
			r.in_year  = random_year();
		end else if (pick < 60) begin
			r.req_type = REQ_NEXT_DAY;
		end else if (pick < 83) begin
			r.req_type = REQ_PREV_DAY;
		end else if (pick < 97) begin
			r.req_type = REQ_COMPARE;
			sel = $urandom_range(0, 4);
			if (sel != 4) begin
				r.in_day   = cal_day;
				r.in_month = cal_month;
				r.in_year  = cal_year;
				case (sel)
					1: r.in_year  = cal_year + 16'($urandom_range(0, 2)) - 16'd1;
					2: r.in_month = cal_month + 4'($urandom_range(0, 2)) - 4'd1;
					3: r.in_day   = cal_day + 5'($urandom_range(0, 2)) - 5'd1;
					default: begin
					end
				endcase
			end
		end else begin
			r.req_type = req_code_t'(REQ_UNUSED);
		end
		return r;
	endfunction

	task automatic add_row(logic [2:0] code, int d, int m, int y, bit pin, cdc_rsp_t want);
		dir_row_t row;
		row.r.req_type = req_code_t'(code);
		row.r.in_day   = 5'(d);
		row.r.in_month = 4'(m);
		row.r.in_year  = 16'(y);
		row.pinned     = pin;
		row.want       = want;
		directed_rows.push_back(row);
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(cdc_req_t r, bit pin, cdc_rsp_t want);
		int gap;
		gap = 0;
		if (!req_steady && $urandom_range(0, 9) < 3) begin
			gap = gap_len();
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_pinned = pin;
		row_want   = want;
		req       <= r;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!req_ready);
		@(negedge clk);
	endtask

	task automatic report_error(string msg);
		$display("ERROR %0t ns, response %0d: %s", $time, rsp_checked, msg);
		err_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want) begin
			report_error($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	always @(posedge clk) begin
		cdc_rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				want = advance_calendar(req);
				if (row_pinned) begin
					want = row_want;
				end
				date_expect_q.push_back(want);
				reqs_accepted++;
				seen_code[req.req_type]++;
			end
			if (rsp_valid && rsp_ready) begin
				if (date_expect_q.size() == 0) begin
					report_error("response with no request outstanding");
				end else begin
					want = date_expect_q.pop_front();
					check_field("cur_day", rsp.cur_day, want.cur_day);
					check_field("cur_month", rsp.cur_month, want.cur_month);
					check_field("cur_year", rsp.cur_year, want.cur_year);
					check_field("accepted", rsp.accepted, want.accepted);
					check_field("stored_less", rsp.stored_less, want.stored_less);
					check_field("stored_equal", rsp.stored_equal, want.stored_equal);
					check_field("stored_greater", rsp.stored_greater, want.stored_greater);
					check_field("gregorian_leap", rsp.gregorian_leap, want.gregorian_leap);
				end
				rsp_checked++;
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// response side: random stalls, steady stretches, long hold-offs on request
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (choke_rsp) begin
				choke_rsp = 1'b0;
				holdoffs++;
				stall_left = CHOKE_CYCLES - 1;
				rsp_ready <= 1'b0;
			end else if (!rsp_steady && $urandom_range(0, 3) == 0) begin
				stall_left = gap_len() - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("Watchdog: %0d cycles without a transfer, %0d responses outstanding",
			idle_cycles, date_expect_q.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		add_row(REQ_COMPARE, 1, 1, 1, 1'b1, rsp_of(1, 1, 1, 0, 0, 1, 0, 0));
		add_row(REQ_PREV_DAY, 0, 0, 0, 1'b1, rsp_of(31, 12, 0, 0, 0, 0, 0, 1));
		add_row(REQ_SET_DAY, 1, 0, 0, 1'b1, rsp_of(1, 12, 0, 1, 0, 0, 0, 1));
		add_row(REQ_SET_MONTH, 0, 1, 0, 1'b1, rsp_of(1, 1, 0, 1, 0, 0, 0, 1));
		add_row(REQ_PREV_DAY, 0, 0, 0, 1'b1, rsp_of(31, 12, 65535, 0, 0, 0, 0, 0));
		add_row(REQ_NEXT_DAY, 0, 0, 0, 1'b1, rsp_of(1, 1, 0, 0, 0, 0, 0, 1));
		add_row(REQ_LOAD, 31, 15, 65535, 1'b1, rsp_of(1, 1, 1, 0, 0, 0, 0, 0));
		add_row(REQ_LOAD, 29, 2, 2000, 1'b1, rsp_of(29, 2, 2000, 1, 0, 0, 0, 1));
		add_row(REQ_NEXT_DAY, 0, 0, 0, 1'b0, '0);
		add_row(REQ_LOAD, 29, 2, 1900, 1'b1, rsp_of(29, 2, 1900, 1, 0, 0, 0, 0));
		add_row(REQ_LOAD, 29, 2, 2001, 1'b1, rsp_of(1, 1, 1, 0, 0, 0, 0, 0));
		add_row(REQ_SET_YEAR, 0, 0, 0, 1'b1, rsp_of(1, 1, 1, 0, 0, 0, 0, 0));
		add_row(REQ_SET_YEAR, 0, 0, 2024, 1'b0, '0);
		add_row(REQ_SET_MONTH, 0, 0, 0, 1'b0, '0);
		add_row(REQ_SET_MONTH, 0, 13, 0, 1'b0, '0);
		add_row(REQ_SET_MONTH, 0, 2, 0, 1'b0, '0);
		add_row(REQ_SET_DAY, 29, 0, 0, 1'b0, '0);
		add_row(REQ_SET_DAY, 30, 0, 0, 1'b0, '0);
		add_row(REQ_SET_DAY, 0, 0, 0, 1'b0, '0);
		add_row(REQ_LOAD, 31, 1, 2023, 1'b0, '0);
		// day 31 kept in April, next day rolls straight into May
		add_row(REQ_SET_MONTH, 0, 4, 0, 1'b0, '0);
		add_row(REQ_NEXT_DAY, 0, 0, 0, 1'b0, '0);
		add_row(REQ_COMPARE, 31, 15, 65535, 1'b0, '0);
		add_row(REQ_COMPARE, 1, 4, 2023, 1'b0, '0);
		add_row(REQ_UNUSED, 31, 15, 65535, 1'b0, '0);

		@(posedge arst_n);
		@(negedge clk);
		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].r, directed_rows[i].pinned, directed_rows[i].want);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				req_steady = ($urandom_range(0, 3) == 0);
				rsp_steady = ($urandom_range(0, 3) == 0);
			end
			if (n % 350 == 10) begin
				choke_rsp  = 1'b1;
				req_steady = 1'b1;
			end
			send_request(random_request(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (date_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Run: %0d requests (%0d directed), %0d responses checked, %0d hold-offs",
			reqs_accepted, directed_rows.size(), rsp_checked, holdoffs);
		$display("By code: load %0d, day %0d, month %0d, year %0d, next %0d, prev %0d,",
			seen_code[REQ_LOAD], seen_code[REQ_SET_DAY], seen_code[REQ_SET_MONTH],
			seen_code[REQ_SET_YEAR], seen_code[REQ_NEXT_DAY], seen_code[REQ_PREV_DAY]);
		$display("  compare %0d, unused %0d; %0d mismatches",
			seen_code[REQ_COMPARE], seen_code[REQ_UNUSED], err_count);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cdc_pkg.sv
rtl/cdc_step.sv
rtl/calendar_date_counter.sv
tb/testbench.sv
